>>> sv/elgamal_byte_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// ElGamal byte cipher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ELGAMAL_BYTE_CIPHER_CORE_DEFINES_SVH
`define ELGAMAL_BYTE_CIPHER_CORE_DEFINES_SVH

// general property under reset gating
`define EBC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ebc assertion failed");

// a signal holds while a guard is high
`define EBC_HOLD(name, guard, sig) \
  name: assert property (@(posedge clk) disable iff (rst) (guard) |=> $stable(sig)) \
    else $error("ebc hold failed");

`endif

>>> sv/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg
// Types, codes and constants of the ElGamal byte cipher.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int MOD_WIDTH_DEFAULT = 31;
  localparam int FIELD_W = 31;
  localparam int WORD_W = 32;
  localparam int EXP_BITS = 31;
  localparam int CFG_INDEX_W = 4;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GENERATOR = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PUBLIC_KEY = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRIVATE_KEY = 4'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [2:0] X_G = 3'd0;
  localparam logic [2:0] X_Y = 3'd1;
  localparam logic [2:0] X_A = 3'd2;
  localparam logic [2:0] X_B = 3'd3;
  localparam logic [2:0] X_ACC = 3'd4;
  localparam logic [2:0] X_SQ = 3'd5;
  localparam logic [2:0] X_MSG = 3'd6;
  localparam logic [2:0] X_Q = 3'd7;

  localparam logic [2:0] Y_ONE = 3'd0;
  localparam logic [2:0] Y_SQ = 3'd1;
  localparam logic [2:0] Y_ACC = 3'd2;
  localparam logic [2:0] Y_T0 = 3'd3;
  localparam logic [2:0] Y_T1 = 3'd4;

  localparam logic D_SQ = 1'b0;
  localparam logic D_ACC = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  message_byte;
    logic [30:0] ephemeral_exp;
    logic [31:0] cipher_a;
    logic [31:0] cipher_b;
  } in_t;

  typedef struct packed {
    logic [30:0] out_a;
    logic [30:0] out_b;
    logic [7:0]  plain_byte;
    logic        no_inverse;
  } out_t;

  typedef struct packed {
    logic       load_item;
    logic       mul_start;
    logic [2:0] mul_x;
    logic [2:0] mul_y;
    logic       mul_dst;
    logic       exp_init;
    logic       exp_shift;
    logic       euc_init;
    logic       div_start;
    logic       euc_step;
    logic       set_out_a;
    logic       set_out_b;
    logic       set_plain;
    logic       set_noinv;
    logic       out_push;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic p_small;
    logic mul_busy;
    logic div_busy;
    logic e_done;
    logic e_bit;
    logic r1_zero;
    logic r0_one;
    logic out_free;
  } status_t;

endpackage

>>> sv/ebc_datapath.sv
// ----------------------------------------------------------------------------
// ebc_datapath
// Key registers, serial modular multiplier, serial divider, Euclid state
// and the output register.
// ----------------------------------------------------------------------------
module ebc_datapath #(
  parameter int MOD_WIDTH = ebc_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ebc_pkg::cmd_t                   cmd,
  output ebc_pkg::status_t                status,
  input  ebc_pkg::in_t                    in_data,
  input  logic                            cfg_valid,
  input  logic [ebc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ebc_pkg::FIELD_W-1:0]     cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ebc_pkg::out_t                   out_data
);
  import ebc_pkg::*;

  localparam int W = MOD_WIDTH;
  localparam int MUL_STEPS = WORD_W;
  localparam int MCNT_W = $clog2(MUL_STEPS + 1);
  localparam int DCNT_W = $clog2(W + 1);
  localparam int ECNT_W = $clog2(EXP_BITS + 1);
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0] p, g, y, x;
  in_t item;
  logic [W-1:0] acc, sq;
  logic [EXP_BITS-1:0] e;
  logic [ECNT_W-1:0] ecnt;
  logic [WORD_W-1:0] mx;
  logic [W-1:0] my, macc;
  logic [MCNT_W-1:0] mcnt;
  logic mdst;
  logic [W-1:0] dn, drem, dq;
  logic [DCNT_W-1:0] dcnt;
  logic [W-1:0] r0, r1, t0, t1;
  logic [W-1:0] res_a, res_b;
  logic [7:0] res_plain;
  logic res_noinv;

  logic [WORD_W-1:0] x_sel;
  logic [W-1:0] y_sel;
  logic [W+1:0] s, p1, p2;
  logic [W-1:0] mstep;
  logic [W:0] trial;
  logic [W-1:0] tn;

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= W'(3);
      g <= W'(2);
      y <= ONE;
      x <= ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODULUS:     p <= cfg_data[W-1:0];
        REG_GENERATOR:   g <= cfg_data[W-1:0];
        REG_PUBLIC_KEY:  y <= cfg_data[W-1:0];
        REG_PRIVATE_KEY: x <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_x)
      X_G:     x_sel = WORD_W'(g);
      X_Y:     x_sel = WORD_W'(y);
      X_A:     x_sel = item.cipher_a;
      X_B:     x_sel = item.cipher_b;
      X_ACC:   x_sel = WORD_W'(acc);
      X_SQ:    x_sel = WORD_W'(sq);
      X_MSG:   x_sel = WORD_W'(item.message_byte);
      X_Q:     x_sel = WORD_W'(dq);
      default: x_sel = '0;
    endcase
    case (cmd.mul_y)
      Y_ONE:   y_sel = ONE;
      Y_SQ:    y_sel = sq;
      Y_ACC:   y_sel = acc;
      Y_T0:    y_sel = t0;
      Y_T1:    y_sel = t1;
      default: y_sel = '0;
    endcase
  end

  always_comb begin
    s = {1'b0, macc, 1'b0} + (mx[WORD_W-1] ? {2'b00, my} : '0);
    p1 = {2'b00, p};
    p2 = {1'b0, p, 1'b0};
    if (s >= p2) begin
      mstep = W'(s - p2);
    end else if (s >= p1) begin
      mstep = W'(s - p1);
    end else begin
      mstep = W'(s);
    end
    trial = {drem, dn[W-1]};
    tn = (t0 >= acc) ? (t0 - acc) : (t0 - acc + p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mul_start) begin
      mcnt <= MCNT_W'(MUL_STEPS);
    end else if (mcnt != '0) begin
      mcnt <= mcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mx <= x_sel;
      my <= y_sel;
      macc <= '0;
      mdst <= cmd.mul_dst;
    end else if (mcnt != '0) begin
      mx <= {mx[WORD_W-2:0], 1'b0};
      macc <= mstep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DCNT_W'(W);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dn <= r0;
      drem <= '0;
      dq <= '0;
    end else if (dcnt != '0) begin
      dn <= {dn[W-2:0], 1'b0};
      if (trial >= {1'b0, r1}) begin
        drem <= W'(trial - {1'b0, r1});
        dq <= {dq[W-2:0], 1'b1};
      end else begin
        drem <= trial[W-1:0];
        dq <= {dq[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
      res_a <= '0;
      res_b <= '0;
      res_plain <= '0;
      res_noinv <= 1'b0;
    end else begin
      if (cmd.set_out_a) res_a <= acc;
      if (cmd.set_out_b) res_b <= acc;
      if (cmd.set_plain) res_plain <= acc[7:0] & BYTE_MASK;
      if (cmd.set_noinv) res_noinv <= 1'b1;
    end
    if (cmd.exp_init) begin
      acc <= ONE;
      e <= (item.op == OP_DECRYPT) ? EXP_BITS'(x) : item.ephemeral_exp;
    end else if (cmd.exp_shift) begin
      e <= {1'b0, e[EXP_BITS-1:1]};
    end
    if (mcnt == MCNT_W'(1)) begin
      if (mdst == D_ACC) acc <= mstep;
      else sq <= mstep;
    end
    if (cmd.euc_init) begin
      r0 <= p;
      r1 <= acc;
      t0 <= '0;
      t1 <= ONE;
    end else if (cmd.euc_step) begin
      r0 <= r1;
      r1 <= drem;
      t0 <= t1;
      t1 <= tn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecnt <= '0;
    end else if (cmd.exp_init) begin
      ecnt <= ECNT_W'(EXP_BITS);
    end else if (cmd.exp_shift) begin
      ecnt <= ecnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      out_data.out_a <= FIELD_W'(res_a);
      out_data.out_b <= FIELD_W'(res_b);
      out_data.plain_byte <= res_plain;
      out_data.no_inverse <= res_noinv;
    end
  end

  always_comb begin
    status.op = item.op;
    status.p_small = (p < W'(2));
    status.mul_busy = (mcnt != '0);
    status.div_busy = (dcnt != '0);
    status.e_done = (ecnt == '0);
    status.e_bit = e[0];
    status.r1_zero = (r1 == '0);
    status.r0_one = (r0 == ONE);
    status.out_free = !out_valid || out_ready;
  end

endmodule

>>> sv/ebc_controller.sv
// ----------------------------------------------------------------------------
// ebc_controller
// Sequencer for reduction, exponentiation, Euclid inverse and result push.
// ----------------------------------------------------------------------------
module ebc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ebc_pkg::status_t status,
  output ebc_pkg::cmd_t    cmd
);
  import ebc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_RED = 4'd2;
  localparam logic [3:0] ST_RED_W = 4'd3;
  localparam logic [3:0] ST_EBIT = 4'd4;
  localparam logic [3:0] ST_EMUL_W = 4'd5;
  localparam logic [3:0] ST_ESQ_W = 4'd6;
  localparam logic [3:0] ST_EDONE = 4'd7;
  localparam logic [3:0] ST_MSG_W = 4'd8;
  localparam logic [3:0] ST_EUC = 4'd9;
  localparam logic [3:0] ST_DIV_W = 4'd10;
  localparam logic [3:0] ST_TMUL_W = 4'd11;
  localparam logic [3:0] ST_FIN_W = 4'd12;
  localparam logic [3:0] ST_PUSH = 4'd13;

  logic [3:0] state, state_next;
  logic phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = '0;
    in_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          phase_next = 1'b0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.p_small) begin
          cmd.set_noinv = (status.op == OP_DECRYPT);
          state_next = ST_PUSH;
        end else begin
          state_next = ST_RED;
        end
      end
      ST_RED: begin
        cmd.mul_start = 1'b1;
        cmd.mul_x = (status.op == OP_DECRYPT) ? X_A : (phase ? X_Y : X_G);
        cmd.mul_y = Y_ONE;
        cmd.mul_dst = D_SQ;
        cmd.exp_init = 1'b1;
        state_next = ST_RED_W;
      end
      ST_RED_W: begin
        if (!status.mul_busy) state_next = ST_EBIT;
      end
      ST_EBIT: begin
        if (status.e_done) begin
          state_next = ST_EDONE;
        end else if (status.e_bit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_x = X_ACC;
          cmd.mul_y = Y_SQ;
          cmd.mul_dst = D_ACC;
          state_next = ST_EMUL_W;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_x = X_SQ;
          cmd.mul_y = Y_SQ;
          cmd.mul_dst = D_SQ;
          state_next = ST_ESQ_W;
        end
      end
      ST_EMUL_W: begin
        if (!status.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_x = X_SQ;
          cmd.mul_y = Y_SQ;
          cmd.mul_dst = D_SQ;
          state_next = ST_ESQ_W;
        end
      end
      ST_ESQ_W: begin
        if (!status.mul_busy) begin
          cmd.exp_shift = 1'b1;
          state_next = ST_EBIT;
        end
      end
      ST_EDONE: begin
        if (status.op == OP_DECRYPT) begin
          cmd.euc_init = 1'b1;
          state_next = ST_EUC;
        end else if (!phase) begin
          cmd.set_out_a = 1'b1;
          phase_next = 1'b1;
          state_next = ST_RED;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_x = X_MSG;
          cmd.mul_y = Y_ACC;
          cmd.mul_dst = D_ACC;
          state_next = ST_MSG_W;
        end
      end
      ST_MSG_W: begin
        if (!status.mul_busy) begin
          cmd.set_out_b = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_EUC: begin
        if (!status.r1_zero) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV_W;
        end else if (status.r0_one) begin
          cmd.mul_start = 1'b1;
          cmd.mul_x = X_B;
          cmd.mul_y = Y_T0;
          cmd.mul_dst = D_ACC;
          state_next = ST_FIN_W;
        end else begin
          cmd.set_noinv = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_DIV_W: begin
        if (!status.div_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_x = X_Q;
          cmd.mul_y = Y_T1;
          cmd.mul_dst = D_ACC;
          state_next = ST_TMUL_W;
        end
      end
      ST_TMUL_W: begin
        if (!status.mul_busy) begin
          cmd.euc_step = 1'b1;
          state_next = ST_EUC;
        end
      end
      ST_FIN_W: begin
        if (!status.mul_busy) begin
          cmd.set_plain = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.out_push = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> sv/elgamal_byte_cipher_core.sv
// ----------------------------------------------------------------------------
// elgamal_byte_cipher_core
// One item at a time. Every modular product runs on a bit-serial multiplier,
// so an exponentiation costs up to about 62 products over the 31 exponent
// bits. Encrypt takes two exponentiations plus one product. Decrypt takes
// one exponentiation followed by an extended Euclid inverse, each Euclid
// round being a serial divide plus one product, about 46 rounds at most.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module elgamal_byte_cipher_core #(
  parameter int MOD_WIDTH = ebc_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ebc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ebc_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ebc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ebc_pkg::FIELD_W-1:0]     cfg_data
);
  import ebc_pkg::*;

  cmd_t cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ebc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ebc_datapath #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/ebc_checker.sv
// ----------------------------------------------------------------------------
// ebc_checker
// Port-level checks of the ElGamal byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "elgamal_byte_cipher_core_defines.svh"

module ebc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ebc_pkg::out_t out_data
);

  `EBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `EBC_HOLD(a_out_stable, out_valid && !out_ready, out_data)
  `EBC_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)
  `EBC_ASSERT(a_noinv_clean, out_valid && out_data.no_inverse |-> out_data.plain_byte == 8'd0 && out_data.out_a == 31'd0 && out_data.out_b == 31'd0)
  `EBC_ASSERT(a_enc_clean, out_valid && (out_data.out_a != 31'd0 || out_data.out_b != 31'd0) |-> out_data.plain_byte == 8'd0)

endmodule

bind elgamal_byte_cipher_core ebc_checker u_ebc_checker (.*);

>>> sim/elgamal_byte_cipher_core_test.sv
// ----------------------------------------------------------------------------
// ElGamal byte cipher core testbench
// Drives encrypt and decrypt items through the core under several key and
// modulus settings, predicts each result in a behavioral model and compares
// every output field in order, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elgamal_byte_cipher_core_test;
  import ebc_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_data;

  logic [63:0] modulus_q;
  logic [63:0] generator_q;
  logic [63:0] pubkey_q;
  logic [63:0] privkey_q;

  out_t cipher_expected[$];
  int errors;
  bit idle_on;

  elgamal_byte_cipher_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] p);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % p;
    sq = base % p;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, sq, p);
      sq = mulmod(sq, sq, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit invmod(logic [63:0] v, logic [63:0] p, output logic [63:0] res);
    longint r0, r1, t0, t1, q, tmp;
    r0 = p;
    r1 = v % p;
    t0 = 0;
    t1 = 1;
    res = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 += p;
    res = t0;
    return 1'b1;
  endfunction

  function automatic out_t cipher_predict(in_t it);
    out_t r;
    logic [63:0] p;
    logic [63:0] inv;
    r = '0;
    p = modulus_q;
    if (it.op == OP_ENCRYPT) begin
      if (p >= 2) begin
        r.out_a = 31'(powmod(generator_q, 64'(it.ephemeral_exp), p));
        r.out_b = 31'(mulmod(powmod(pubkey_q, 64'(it.ephemeral_exp), p),
                             64'(it.message_byte), p));
      end
    end else if (p < 2) begin
      r.no_inverse = 1'b1;
    end else if (!invmod(powmod(64'(it.cipher_a), privkey_q, p), p, inv)) begin
      r.no_inverse = 1'b1;
    end else begin
      r.plain_byte = 8'(mulmod(64'(it.cipher_b), inv, p));
    end
    return r;
  endfunction

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_item(in_t it);
    idle_gap();
    cipher_expected = {cipher_expected, cipher_predict(it)};
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODULUS: modulus_q = 64'(val);
      REG_GENERATOR: generator_q = 64'(val);
      REG_PUBLIC_KEY: pubkey_q = 64'(val);
      REG_PRIVATE_KEY: privkey_q = 64'(val);
      default: ;
    endcase
  endtask

  task automatic set_keys(logic [30:0] p, logic [30:0] g, logic [30:0] y, logic [30:0] x);
    wait_drain();
    write_reg(REG_MODULUS, p);
    write_reg(REG_GENERATOR, g);
    write_reg(REG_PUBLIC_KEY, y);
    write_reg(REG_PRIVATE_KEY, x);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t rand_item(bit op);
    in_t it;
    it.op = op;
    it.message_byte = 8'($urandom);
    it.ephemeral_exp = 31'($urandom) | 31'd1;
    it.cipher_a = $urandom;
    it.cipher_b = $urandom;
    if ($urandom_range(0, 3) == 0) it.ephemeral_exp = 31'($urandom_range(1, 300));
    return it;
  endfunction

  function automatic in_t enc_item(logic [7:0] m, logic [30:0] k);
    in_t it;
    it = '0;
    it.op = OP_ENCRYPT;
    it.message_byte = m;
    it.ephemeral_exp = k;
    return it;
  endfunction

  function automatic in_t dec_item(logic [31:0] a, logic [31:0] b);
    in_t it;
    it = '0;
    it.op = OP_DECRYPT;
    it.cipher_a = a;
    it.cipher_b = b;
    return it;
  endfunction

  task automatic test_reset_values();
    send_item(enc_item(8'd0, 31'd1));
    send_item(enc_item(8'hff, 31'h7fffffff));
    send_item(dec_item(32'd2, 32'd1));
    send_item(dec_item(32'd3, 32'd5));
  endtask

  task automatic test_directed();
    set_keys(31'd257, 31'd3, 31'd3, 31'd0);
    send_item(enc_item(8'hff, 31'd1));
    send_item(enc_item(8'h80, 31'd256));
    send_item(dec_item(32'd257, 32'd100));
    send_item(dec_item(32'hffffffff, 32'hffffffff));
    set_keys(31'h7fffffff, 31'h7ffffffe, 31'h7ffffffe, 31'h7fffffff);
    send_item(enc_item(8'hff, 31'h7fffffff));
    send_item(enc_item(8'h00, 31'd2));
    send_item(dec_item(32'hffffffff, 32'h80000000));
    send_item(dec_item(32'h7fffffff, 32'd9));
    send_item(dec_item(32'd0, 32'd9));
    set_keys(31'd1, 31'd0, 31'd0, 31'd5);
    send_item(enc_item(8'h55, 31'd7));
    send_item(dec_item(32'd3, 32'd4));
    set_keys(31'd0, 31'd2, 31'd2, 31'd2);
    send_item(enc_item(8'haa, 31'd7));
    send_item(dec_item(32'd3, 32'd4));
    set_keys(31'd91, 31'd5, 31'd12, 31'd3);
    send_item(enc_item(8'h33, 31'd13));
    send_item(dec_item(32'd7, 32'd22));
  endtask

  task automatic test_random_roundtrip();
    logic [30:0] primes[4] = '{31'd251, 31'd65521, 31'd1000003, 31'h7fffffff};
    logic [30:0] p, g, x;
    in_t it;
    out_t enc;
    for (int s = 0; s < 4; s++) begin
      p = primes[s];
      g = 31'($urandom_range(2, p - 1));
      x = 31'($urandom);
      set_keys(p, g, 31'(powmod(64'(g), 64'(x), 64'(p))), x);
      for (int n = 0; n < 22; n++) begin
        it = rand_item(1'($urandom_range(0, 1)));
        if (it.op == OP_ENCRYPT && $urandom_range(0, 1)) begin
          send_item(it);
          enc = cipher_predict(it);
          send_item(dec_item(32'(enc.out_a), 32'(enc.out_b)));
        end else begin
          send_item(it);
        end
      end
    end
    set_keys(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
    for (int n = 0; n < 10; n++) send_item(rand_item(1'($urandom_range(0, 1))));
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
        @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (cipher_expected.size() == 0) begin
        $error("result with no expectation: %h", out_data);
        errors++;
      end else begin
        e = cipher_expected.pop_front();
        if (out_data.out_a !== e.out_a) begin
          $error("out_a expected %h actual %h", e.out_a, out_data.out_a);
          errors++;
        end
        if (out_data.out_b !== e.out_b) begin
          $error("out_b expected %h actual %h", e.out_b, out_data.out_b);
          errors++;
        end
        if (out_data.plain_byte !== e.plain_byte) begin
          $error("plain_byte expected %h actual %h", e.plain_byte, out_data.plain_byte);
          errors++;
        end
        if (out_data.no_inverse !== e.no_inverse) begin
          $error("no_inverse expected %b actual %b", e.no_inverse, out_data.no_inverse);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    modulus_q = 64'd3;
    generator_q = 64'd2;
    pubkey_q = 64'd1;
    privkey_q = 64'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random_roundtrip();
    idle_on = 1'b0;
    for (int n = 0; n < 6; n++) send_item(rand_item(1'($urandom_range(0, 1))));
    wait_drain();
    if (errors == 0 && cipher_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> elgamal_byte_cipher_core.f
+incdir+sv
sv/ebc_pkg.sv
sv/ebc_datapath.sv
sv/ebc_controller.sv
sv/elgamal_byte_cipher_core.sv
sv/ebc_checker.sv
sim/elgamal_byte_cipher_core_test.sv
